// File: rtl/core/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Types and constants shared by the weekly schedule relay switch modules.
// ----------------------------------------------------------------------------
package wss_pkg;

   localparam int SEC_W  = 17;
   localparam int SLOT_W = 5;

   localparam logic [1:0] REQ_WRITE_REC  = 2'd0;
   localparam logic [1:0] REQ_WRITE_ONCE = 2'd1;
   localparam logic [1:0] REQ_TICK       = 2'd2;

   localparam logic [4:0] HOUR_LIMIT    = 5'd24;
   localparam logic [5:0] MINSEC_LIMIT  = 6'd60;
   localparam logic [SEC_W-1:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [SEC_W-1:0] SECS_PER_MIN  = 17'd60;

   localparam logic [SLOT_W-1:0] SLOT_ONE_TIME = 5'd16;
   localparam logic [SLOT_W-1:0] SLOT_NONE     = 5'd17;

   typedef struct packed {
      logic             active;
      logic [SEC_W-1:0] start_s;
      logic [SEC_W-1:0] end_s;
      logic [6:0]       mask;
   } window_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] index;
      logic       write_good;
      window_type window;
      logic [2:0] day;
   } cmd_type;

   typedef struct packed {
      logic              write_ok;
      logic              one_time_expired;
      logic [SLOT_W-1:0] matched_slot;
      logic              relay_changed;
      logic              relay_on;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DONE
   } seq_state_type;

   function automatic logic [SEC_W-1:0] to_seconds(input logic [4:0] h, input logic [5:0] m,
                                                   input logic [5:0] s);
      to_seconds = SEC_W'(h) * SECS_PER_HOUR + SEC_W'(m) * SECS_PER_MIN + SEC_W'(s);
   endfunction

   function automatic logic time_ok(input logic [4:0] h, input logic [5:0] m,
                                    input logic [5:0] s);
      time_ok = (h < HOUR_LIMIT) && (m < MINSEC_LIMIT) && (s < MINSEC_LIMIT);
   endfunction

   function automatic logic covers(input logic [SEC_W-1:0] now, input window_type w);
      covers = (now >= w.start_s) && (now <= w.end_s);
   endfunction

   function automatic logic window_hit(input window_type w, input logic [SEC_W-1:0] now,
                                       input logic [2:0] day);
      logic [7:0] daybit;
      daybit     = 8'd1 << day;
      window_hit = w.active && covers(now, w) && ((w.mask & daybit[6:0]) != 7'd0);
   endfunction

endpackage

// File: rtl/core/wss_window_mem.sv
// ----------------------------------------------------------------------------
// wss_window_mem
// Recurring window store: one write port, one registered read port, with a
// valid bit per entry so that never-written entries read as inactive.
// ----------------------------------------------------------------------------
module wss_window_mem #(
   parameter int NUM_WINDOWS = 16
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   wr_en,
   input  logic [(NUM_WINDOWS > 1 ? $clog2(NUM_WINDOWS) : 1)-1:0] wr_addr,
   input  wss_pkg::window_type                                    wr_data,
   input  logic                                                   rd_en,
   input  logic [(NUM_WINDOWS > 1 ? $clog2(NUM_WINDOWS) : 1)-1:0] rd_addr,
   output wss_pkg::window_type                                    rd_data
);
   import wss_pkg::*;

   window_type             mem_ff [NUM_WINDOWS];
   window_type             rd_ff;
   logic [NUM_WINDOWS-1:0] valid_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_comb begin
      rd_data        = rd_ff;
      rd_data.active = rd_ff.active && rd_valid_ff;
   end

endmodule

// File: rtl/core/wss_sequencer.sv
// ----------------------------------------------------------------------------
// wss_sequencer
// Executes one request: stores windows, or walks the window store one entry
// a cycle, tries the one-time window and updates the relay.
// ----------------------------------------------------------------------------
module wss_sequencer #(
   parameter int NUM_WINDOWS = 16
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   sched_en,
   input  logic                                                   cmd_valid,
   output logic                                                   cmd_ready,
   input  wss_pkg::cmd_type                                       cmd,
   output logic                                                   mem_wr_en,
   output logic [(NUM_WINDOWS > 1 ? $clog2(NUM_WINDOWS) : 1)-1:0] mem_wr_addr,
   output wss_pkg::window_type                                    mem_wr_data,
   output logic                                                   mem_rd_en,
   output logic [(NUM_WINDOWS > 1 ? $clog2(NUM_WINDOWS) : 1)-1:0] mem_rd_addr,
   input  wss_pkg::window_type                                    mem_rd_data,
   output logic                                                   res_valid,
   input  logic                                                   res_take,
   output wss_pkg::result_type                                    res
);
   import wss_pkg::*;

   localparam int IDX_W = NUM_WINDOWS > 1 ? $clog2(NUM_WINDOWS) : 1;
   localparam int CNT_W = $clog2(NUM_WINDOWS + 1);

   seq_state_type state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic          relay_ff, relay_in;
   window_type    once_ff, once_in;
   result_type    res_ff, res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         relay_ff <= 1'b0;
         once_ff  <= '0;
      end else begin
         state_ff <= state_in;
         relay_ff <= relay_in;
         once_ff  <= once_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   always_comb begin
      logic             want;
      logic             fin;
      logic             expired;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0] ev_idx;

      state_in    = state_ff;
      cmd_in      = cmd_ff;
      cnt_in      = cnt_ff;
      relay_in    = relay_ff;
      once_in     = once_ff;
      res_in      = res_ff;
      cmd_ready   = (state_ff == ST_IDLE);
      res_valid   = (state_ff == ST_DONE);
      res         = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = IDX_W'(cmd_ff.index);
      mem_wr_data = cmd_ff.window;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      want        = 1'b0;
      fin         = 1'b0;
      expired     = 1'b0;
      slot        = SLOT_NONE;
      ev_idx      = CNT_W'(cnt_ff - CNT_W'(1));

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in.write_ok         = 1'b0;
            res_in.one_time_expired = 1'b0;
            res_in.matched_slot     = SLOT_NONE;
            res_in.relay_changed    = 1'b0;
            res_in.relay_on         = relay_ff;
            state_in                = ST_DONE;
            case (cmd_ff.kind)
               REQ_WRITE_REC: begin
                  if (cmd_ff.write_good && (32'(cmd_ff.index) < NUM_WINDOWS)) begin
                     mem_wr_en       = 1'b1;
                     res_in.write_ok = 1'b1;
                  end
               end
               REQ_WRITE_ONCE: begin
                  if (cmd_ff.write_good) begin
                     once_in         = cmd_ff.window;
                     res_in.write_ok = 1'b1;
                  end
               end
               REQ_TICK: begin
                  if (sched_en) begin
                     mem_rd_en = 1'b1;
                     cnt_in    = CNT_W'(1);
                     state_in  = ST_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            if (window_hit(mem_rd_data, cmd_ff.window.start_s, cmd_ff.day)) begin
               slot = SLOT_W'(ev_idx);
               want = 1'b1;
               fin  = 1'b1;
            end else if (cnt_ff == CNT_W'(NUM_WINDOWS)) begin
               fin = 1'b1;
               if (once_ff.active) begin
                  if (window_hit(once_ff, cmd_ff.window.start_s, cmd_ff.day)) begin
                     slot = SLOT_ONE_TIME;
                     want = 1'b1;
                  end else if ((cmd_ff.window.start_s >= once_ff.start_s) &&
                               (cmd_ff.window.start_s > once_ff.end_s)) begin
                     once_in.active = 1'b0;
                     expired        = 1'b1;
                  end
               end
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cnt_ff[IDX_W-1:0];
               cnt_in      = CNT_W'(cnt_ff + CNT_W'(1));
            end
            if (fin) begin
               relay_in                = want;
               res_in.relay_on         = want;
               res_in.relay_changed    = (want != relay_ff);
               res_in.matched_slot     = slot;
               res_in.one_time_expired = expired;
               state_in                = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/weekly_schedule_relay_switch.sv
// ----------------------------------------------------------------------------
// weekly_schedule_relay_switch
// Relay driven by a store of recurring weekly time windows and one one-time
// window; write items store windows, tick items update the relay.
// ----------------------------------------------------------------------------
// Flow: an accepted item passes ST_EXEC, then for an enabled tick ST_SCAN, which
//   walks the window store through its single read port up to the first matching
//   window, then ST_DONE; the result is registered into rsp_tdata. One item at a
//   time: a new item is taken only after the last result has left ST_DONE.
// Reset: relay off, all windows inactive, scheduling disabled; no clearing pass.
module weekly_schedule_relay_switch #(
   parameter int NUM_WINDOWS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // entry_index, active, time_a_hour, time_a_minute, time_a_second, end_hour,
   // end_minute, end_second, weekday_mask, day_of_week, zero fill
   input  logic [55:0] req_tdata,
   // req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // relay_on, relay_changed, matched_slot, one_time_expired, write_ok, zero fill
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import wss_pkg::*;

   localparam int IDX_W = NUM_WINDOWS > 1 ? $clog2(NUM_WINDOWS) : 1;

   cmd_type    cmd;
   logic       enable_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       res_valid;
   logic       res_take;
   result_type res;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   window_type       mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   window_type       mem_rd_data;

   always_comb begin
      cmd.kind           = req_tuser;
      cmd.index          = req_tdata[3:0];
      cmd.window.active  = req_tdata[4];
      cmd.window.start_s = to_seconds(req_tdata[9:5], req_tdata[15:10], req_tdata[21:16]);
      cmd.window.end_s   = to_seconds(req_tdata[26:22], req_tdata[32:27], req_tdata[38:33]);
      cmd.window.mask    = req_tdata[45:39];
      cmd.day            = req_tdata[48:46];
      cmd.write_good     = time_ok(req_tdata[9:5], req_tdata[15:10], req_tdata[21:16]) &&
                           time_ok(req_tdata[26:22], req_tdata[32:27], req_tdata[38:33]);
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_valid) begin
         enable_ff <= csr_data;
      end
   end

   assign res_take     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (res_valid && res_take) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff};

   wss_window_mem #(
      .NUM_WINDOWS(NUM_WINDOWS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   wss_sequencer #(
      .NUM_WINDOWS(NUM_WINDOWS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .sched_en    (enable_ff),
      .cmd_valid   (req_tvalid),
      .cmd_ready   (req_tready),
      .cmd         (cmd),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res         (res)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in flight");

   a_match_drives_relay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.matched_slot != SLOT_NONE) |-> rsp_ff.relay_on)
      else $error("matched window without relay on");

   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.write_ok |->
         !rsp_ff.relay_changed && !rsp_ff.one_time_expired &&
         (rsp_ff.matched_slot == SLOT_NONE))
      else $error("write item reported tick activity");

   a_no_write_while_scan: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |-> !mem_wr_en)
      else $error("window store read and written in one cycle");

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// weekly_schedule_relay_switch testbench
// Drives window writes, one-time writes, ticks and spare request codes into
// the switch. A scoreboard keeps its own copy of the window store, the
// one-time window, the relay and the enable bit, predicts the result of each
// accepted item and compares it field by field with the result stream.
// Both stream sides stall at random in two idling patterns and run without
// stalls in a third; enable is toggled between phases while the switch is idle.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import wss_pkg::*;

   localparam int         NUM_SLOTS   = 16;
   localparam int         QUIET_LIMIT = 4000;
   localparam int         SHOW_LIMIT  = 10;
   localparam logic [1:0] REQ_SPARE   = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] index;
      logic       active;
      logic [4:0] a_hour;
      logic [5:0] a_minute;
      logic [5:0] a_second;
      logic [4:0] e_hour;
      logic [5:0] e_minute;
      logic [5:0] e_second;
      logic [6:0] mask;
      logic [2:0] day;
   } switch_request_type;

   class relay_schedule_board;
      window_type windows [NUM_SLOTS];
      window_type once_window;
      logic       relay;
      logic       enabled;
      result_type awaited [$];
      int         failures;

      function new();
         foreach (windows[i]) windows[i] = '0;
         once_window = '0;
         relay       = 1'b0;
         enabled     = 1'b0;
         failures    = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function logic [SEC_W-1:0] day_seconds(logic [4:0] h, logic [5:0] m, logic [5:0] s);
         return SEC_W'(h * 3600 + m * 60 + s);
      endfunction

      function logic window_covers(window_type w, logic [SEC_W-1:0] now, logic [7:0] daybit);
         return w.active && now >= w.start_s && now <= w.end_s &&
                ((w.mask & daybit[6:0]) != 7'd0);
      endfunction

      function void note_request(switch_request_type r);
         result_type       res;
         window_type       w;
         logic [SEC_W-1:0] now;
         logic [7:0]       daybit;
         logic             good;
         logic             want;
         res              = '0;
         res.matched_slot = SLOT_NONE;
         if (r.kind == REQ_WRITE_REC || r.kind == REQ_WRITE_ONCE) begin
            good = r.a_hour < HOUR_LIMIT && r.a_minute < MINSEC_LIMIT &&
                   r.a_second < MINSEC_LIMIT && r.e_hour < HOUR_LIMIT &&
                   r.e_minute < MINSEC_LIMIT && r.e_second < MINSEC_LIMIT;
            if (r.kind == REQ_WRITE_REC && int'(r.index) >= NUM_SLOTS) good = 1'b0;
            if (good) begin
               w.active  = r.active;
               w.start_s = day_seconds(r.a_hour, r.a_minute, r.a_second);
               w.end_s   = day_seconds(r.e_hour, r.e_minute, r.e_second);
               w.mask    = r.mask;
               if (r.kind == REQ_WRITE_REC) windows[r.index] = w;
               else once_window = w;
               res.write_ok = 1'b1;
            end
         end else if (r.kind == REQ_TICK && enabled) begin
            now    = day_seconds(r.a_hour, r.a_minute, r.a_second);
            daybit = 8'd1 << r.day;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (res.matched_slot == SLOT_NONE && window_covers(windows[i], now, daybit))
                  res.matched_slot = SLOT_W'(i);
            end
            if (res.matched_slot == SLOT_NONE && once_window.active) begin
               if (window_covers(once_window, now, daybit)) begin
                  res.matched_slot = SLOT_ONE_TIME;
               end else if (now >= once_window.start_s && now > once_window.end_s) begin
                  once_window.active   = 1'b0;
                  res.one_time_expired = 1'b1;
               end
            end
            want = (res.matched_slot != SLOT_NONE);
            if (want != relay) begin
               relay             = want;
               res.relay_changed = 1'b1;
            end
         end
         res.relay_on = relay;
         awaited.push_back(res);
      endfunction

      function void check_response(logic [15:0] data);
         result_type got;
         result_type want;
         got = data[8:0];
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= SHOW_LIMIT)
               $display("%0t: result %h arrived with nothing awaited", $realtime, data);
            return;
         end
         want = awaited.pop_front();
         if (got.relay_on !== want.relay_on || got.relay_changed !== want.relay_changed ||
             got.matched_slot !== want.matched_slot ||
             got.one_time_expired !== want.one_time_expired ||
             got.write_ok !== want.write_ok) begin
            failures++;
            if (failures <= SHOW_LIMIT)
               $display({"%0t: mismatch on/chg/slot/exp/ok expected %0d/%0d/%0d/%0d/%0d",
                         " got %0d/%0d/%0d/%0d/%0d"},
                        $realtime, want.relay_on, want.relay_changed, want.matched_slot,
                        want.one_time_expired, want.write_ok, got.relay_on, got.relay_changed,
                        got.matched_slot, got.one_time_expired, got.write_ok);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;

   int req_idle_pct = 25;
   int rsp_idle_pct = 66;
   int quiet_cycles = 0;

   relay_schedule_board board = new();

   weekly_schedule_relay_switch #(
      .NUM_WINDOWS(NUM_SLOTS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("weekly_schedule_relay_switch regression: fail");
         $finish;
      end
   end

   function automatic logic [55:0] pack_request(switch_request_type r);
      return {7'd0, r.day, r.mask, r.e_second, r.e_minute, r.e_hour,
              r.a_second, r.a_minute, r.a_hour, r.active, r.index};
   endfunction

   function automatic switch_request_type make_write(logic [1:0] kind, logic [3:0] index,
                                                     logic active, logic [4:0] hh,
                                                     logic [5:0] mm, logic [5:0] ss,
                                                     logic [4:0] eh, logic [5:0] em,
                                                     logic [5:0] es, logic [6:0] mask);
      switch_request_type r;
      r = '0;
      r.kind     = kind;
      r.index    = index;
      r.active   = active;
      r.a_hour   = hh;
      r.a_minute = mm;
      r.a_second = ss;
      r.e_hour   = eh;
      r.e_minute = em;
      r.e_second = es;
      r.mask     = mask;
      return r;
   endfunction

   function automatic switch_request_type make_tick(logic [4:0] hh, logic [5:0] mm,
                                                    logic [5:0] ss, logic [2:0] day);
      switch_request_type r;
      r = '0;
      r.kind     = REQ_TICK;
      r.a_hour   = hh;
      r.a_minute = mm;
      r.a_second = ss;
      r.day      = day;
      return r;
   endfunction

   function automatic switch_request_type random_request();
      switch_request_type r;
      int unsigned        pick;
      logic               wide;
      pick       = $urandom_range(99);
      r.kind     = pick < 35 ? REQ_WRITE_REC : pick < 45 ? REQ_WRITE_ONCE :
                   pick < 95 ? REQ_TICK : REQ_SPARE;
      r.index    = 4'($urandom);
      r.active   = ($urandom_range(9) != 0);
      r.mask     = 7'($urandom);
      r.day      = ($urandom_range(9) == 0) ? 3'd7 : 3'($urandom_range(6));
      wide       = (r.kind == REQ_SPARE) || ($urandom_range(9) == 0);
      r.a_hour   = wide ? 5'($urandom) : 5'($urandom_range(23));
      r.a_minute = wide ? 6'($urandom) : 6'($urandom_range(59));
      r.a_second = wide ? 6'($urandom) : 6'($urandom_range(59));
      r.e_hour   = wide ? 5'($urandom) : 5'($urandom_range(23));
      r.e_minute = wide ? 6'($urandom) : 6'($urandom_range(59));
      r.e_second = wide ? 6'($urandom) : 6'($urandom_range(59));
      return r;
   endfunction

   task automatic send_request(input switch_request_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_request(r);
      req_tuser  <= r.kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_enable(input logic value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      board.enabled  = value;
   endtask

   task automatic send_random(input int count);
      repeat (count) send_request(random_request());
   endtask

   initial begin
      switch_request_type spare;
      spare      = '1;
      spare.kind = REQ_SPARE;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // scheduling still disabled: ticks and spare codes change nothing
      send_request(make_tick(5'd12, 6'd0, 6'd0, 3'd0));
      send_request(spare);
      send_request(make_write(REQ_WRITE_REC, 4'd0, 1'b1, 5'd8, 6'd0, 6'd0,
                              5'd17, 6'd59, 6'd59, 7'h7F));
      send_request(make_write(REQ_WRITE_REC, 4'd15, 1'b1, 5'd0, 6'd0, 6'd0,
                              5'd23, 6'd59, 6'd59, 7'h01));
      send_request(make_write(REQ_WRITE_REC, 4'd5, 1'b1, 5'd24, 6'd0, 6'd0,
                              5'd23, 6'd0, 6'd0, 7'h7F));
      send_request(make_write(REQ_WRITE_REC, 4'd1, 1'b1, 5'd1, 6'd60, 6'd0,
                              5'd2, 6'd60, 6'd0, 7'h7F));
      send_request(make_write(REQ_WRITE_REC, 4'd2, 1'b1, 5'd1, 6'd0, 6'd60,
                              5'd2, 6'd0, 6'd60, 7'h7F));
      send_request(make_write(REQ_WRITE_REC, 4'd3, 1'b1, 5'd20, 6'd0, 6'd0,
                              5'd10, 6'd0, 6'd0, 7'h7F));
      send_request(make_write(REQ_WRITE_ONCE, 4'd0, 1'b1, 5'd18, 6'd0, 6'd0,
                              5'd24, 6'd0, 6'd0, 7'h40));
      send_request(make_write(REQ_WRITE_ONCE, 4'd0, 1'b1, 5'd18, 6'd0, 6'd0,
                              5'd18, 6'd30, 6'd0, 7'h40));
      send_request(make_tick(5'd18, 6'd10, 6'd0, 3'd6));

      write_enable(1'b1);
      send_request(make_tick(5'd12, 6'd0, 6'd0, 3'd0));
      send_request(make_tick(5'd7, 6'd0, 6'd0, 3'd0));
      send_request(make_tick(5'd7, 6'd0, 6'd0, 3'd1));
      send_request(make_tick(5'd18, 6'd10, 6'd0, 3'd6));
      send_request(make_tick(5'd18, 6'd10, 6'd0, 3'd7));
      send_request(make_tick(5'd18, 6'd45, 6'd0, 3'd2));
      send_request(make_tick(5'd31, 6'd63, 6'd63, 3'd7));
      send_request(make_write(REQ_WRITE_REC, 4'd0, 1'b0, 5'd0, 6'd0, 6'd0,
                              5'd0, 6'd0, 6'd0, 7'h00));
      send_request(make_tick(5'd12, 6'd0, 6'd0, 3'd0));
      send_request(make_write(REQ_WRITE_REC, 4'd15, 1'b1, 5'd23, 6'd59, 6'd59,
                              5'd23, 6'd59, 6'd59, 7'h7F));
      send_request(make_tick(5'd23, 6'd59, 6'd59, 3'd3));
      send_request(make_tick(5'd0, 6'd0, 6'd0, 3'd4));

      send_random(200);

      write_enable(1'b0);
      req_idle_pct = 66;
      rsp_idle_pct = 25;
      send_random(60);
      write_enable(1'b1);
      send_random(140);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random(200);

      drain_results();
      repeat (NUM_SLOTS + 8) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("weekly_schedule_relay_switch regression: pass");
      else
         $display("weekly_schedule_relay_switch regression: fail");
      $finish;
   end

endmodule

// File: files.f
rtl/core/wss_pkg.sv
rtl/core/wss_window_mem.sv
rtl/core/wss_sequencer.sv
rtl/core/weekly_schedule_relay_switch.sv
sim/testbench.sv
